@@ design/luhn_pkg.sv @@
`timescale 1ns / 1ps

package luhn_pkg;

  localparam int unsigned DigitW = 4;
  localparam int unsigned LenW   = 5;
  localparam int unsigned SumW   = 4;

  localparam logic [LenW-1:0]   MaxCount = 5'd31;
  localparam logic [DigitW-1:0] MaxDigit = 4'd9;

  typedef enum logic [1:0] {
    KindInvalid    = 2'd0,
    KindAmex       = 2'd1,
    KindMastercard = 2'd2,
    KindVisa       = 2'd3
  } card_kind_e;

  typedef struct packed {
    card_kind_e      card_kind;
    logic            checksum_ok;
    logic [LenW-1:0] length_seen;
  } result_t;

  // luhn doubling: 2d with the digits of the product summed
  function automatic logic [SumW-1:0] doubled_digit(input logic [DigitW-1:0] d);
    logic [SumW-1:0] r;
    unique case (d)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd6;
      4'd4:    r = 4'd8;
      4'd5:    r = 4'd1;
      4'd6:    r = 4'd3;
      4'd7:    r = 4'd5;
      4'd8:    r = 4'd7;
      default: r = 4'd9;
    endcase
    return r;
  endfunction

  // both operands stay below ten, so one conditional subtract suffices
  function automatic logic [SumW-1:0] add_mod10(input logic [SumW-1:0] s,
                                                input logic [SumW-1:0] v);
    logic [SumW:0] t;
    t = {1'b0, s} + {1'b0, v};
    if (t >= 5'd10) begin
      t = t - 5'd10;
    end
    return t[SumW-1:0];
  endfunction

endpackage

@@ design/luhn_digit_if.sv @@
`timescale 1ns / 1ps

interface luhn_digit_if;
  import luhn_pkg::*;

  logic              valid;
  logic              ready;
  logic [DigitW-1:0] digit;
  logic              last_digit;

  modport source (output valid, output digit, output last_digit, input ready);
  modport sink (input valid, input digit, input last_digit, output ready);
endinterface

@@ design/luhn_result_if.sv @@
`timescale 1ns / 1ps

interface luhn_result_if;
  import luhn_pkg::*;

  logic            valid;
  logic            ready;
  logic [1:0]      card_kind;
  logic            checksum_ok;
  logic [LenW-1:0] length_seen;

  modport source (output valid, output card_kind, output checksum_ok, output length_seen,
                  input ready);
  modport sink (input valid, input card_kind, input checksum_ok, input length_seen,
                output ready);
endinterface

@@ design/luhn_acc.sv @@
`timescale 1ns / 1ps

module luhn_acc import luhn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [DigitW-1:0] digit_i,
  input  logic              last_i,
  output result_t           result_o
);

  logic [LenW-1:0]   count_q, count_d;
  logic [SumW-1:0]   sum_even_q, sum_even_d;
  logic [SumW-1:0]   sum_odd_q, sum_odd_d;
  logic [DigitW-1:0] lead_q, lead_d;
  logic [DigitW-1:0] second_q, second_d;

  logic [DigitW-1:0] dig;
  logic [SumW-1:0]   dbl;
  logic              pos_odd;
  logic [SumW-1:0]   sum_sel;
  logic [SumW-1:0]   lead_n, second_n;
  logic [LenW-1:0]   len;
  logic              ok;
  card_kind_e        kind;

  always_comb begin
    dig     = (digit_i > MaxDigit) ? MaxDigit : digit_i;
    dbl     = doubled_digit(dig);
    pos_odd = count_q[0];

    lead_n   = (count_q == '0) ? dig : lead_q;
    second_n = (count_q == LenW'(1)) ? dig : second_q;

    sum_even_d = add_mod10(sum_even_q, pos_odd ? dig : dbl);
    sum_odd_d  = add_mod10(sum_odd_q, pos_odd ? dbl : dig);
    len        = (count_q < MaxCount) ? count_q + LenW'(1) : count_q;

    sum_sel = len[0] ? sum_odd_d : sum_even_d;
    ok      = (sum_sel == '0);

    priority if (len == 5'd15 && lead_n == 4'd3 && (second_n == 4'd4 || second_n == 4'd7)) begin
      kind = KindAmex;
    end else if (len == 5'd16 && lead_n == 4'd5 && second_n >= 4'd1 && second_n <= 4'd5) begin
      kind = KindMastercard;
    end else if ((len == 5'd13 || len == 5'd16) && lead_n == 4'd4) begin
      kind = KindVisa;
    end else begin
      kind = KindInvalid;
    end

    result_o.card_kind   = ok ? kind : KindInvalid;
    result_o.checksum_ok = ok;
    result_o.length_seen = len;

    // a finished number leaves the state cleared for the next one
    if (last_i) begin
      count_d  = '0;
      lead_d   = '0;
      second_d = '0;
    end else begin
      count_d  = len;
      lead_d   = lead_n;
      second_d = second_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      sum_even_q <= '0;
      sum_odd_q  <= '0;
      lead_q     <= '0;
      second_q   <= '0;
    end else if (step_i) begin
      count_q    <= count_d;
      sum_even_q <= last_i ? '0 : sum_even_d;
      sum_odd_q  <= last_i ? '0 : sum_odd_d;
      lead_q     <= lead_d;
      second_q   <= second_d;
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> count_q == '0 && sum_even_q == '0 && sum_odd_q == '0)
    else $error("state not cleared after final digit");

  a_sums_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_even_q < 4'd10 && sum_odd_q < 4'd10)
    else $error("running sum left mod-10 range");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !last_i && count_q < MaxCount |=> count_q == $past(count_q) + LenW'(1))
    else $error("digit count did not advance");

endmodule

@@ design/luhn_card_number_check.sv @@
`timescale 1ns / 1ps

// Luhn card number checker. Digits arrive on digit_i one per transfer, most
// significant first, with last_digit set on the final one; that transfer
// yields a single result on result_o (card class, checksum flag and digit
// count saturating at 31), other digits yield nothing. Throughput is one
// digit per cycle unless a stall holds the input: a digit is first registered
// in the input register, then the running sums update and any result is
// captured in the output register. Only a final digit waiting behind an
// untaken result holds the input back.
module luhn_card_number_check import luhn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  luhn_digit_if.sink    digit_i,
  luhn_result_if.source result_o
);

  logic              in_valid_q;
  logic [DigitW-1:0] in_digit_q;
  logic              in_last_q;
  logic              advance;

  logic              out_valid_q, out_valid_d;
  result_t           out_q;
  result_t           res;

  // a non-final digit only updates the accumulator state, so it never waits on the output
  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || result_o.ready);
  assign digit_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (digit_i.ready) begin
      in_valid_q <= digit_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (digit_i.ready && digit_i.valid) begin
      in_digit_q <= digit_i.digit;
      in_last_q  <= digit_i.last_digit;
    end
  end

  luhn_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .digit_i  (in_digit_q),
    .last_i   (in_last_q),
    .result_o (res)
  );

  always_comb begin
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_q <= res;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.card_kind   = out_q.card_kind;
  assign result_o.checksum_ok = out_q.checksum_ok;
  assign result_o.length_seen = out_q.length_seen;

  a_kind_needs_checksum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.checksum_ok || out_q.card_kind == KindInvalid)
    else $error("card class given with failed checksum");

  a_length_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.length_seen != '0)
    else $error("result with zero length");

  a_final_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && in_last_q && out_valid_q && !result_o.ready |-> !digit_i.ready && !advance)
    else $error("final digit advanced over untaken result");

endmodule
